// ===== src/apool_pkg.sv =====
// shared types, constants and helper functions of the average pooling block
package apool_pkg;

   localparam int LANES       = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int POS_W       = 7;
   localparam int SIZE_W      = 4;
   localparam int SLOT_W      = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int ACC_W       = SAMPLE_BITS + 6;
   localparam int RECIP_W     = 17;
   localparam int PROD_W      = ACC_W + RECIP_W + 1;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_POOL_MAX = 8;

   localparam logic [CSR_IDX_W-1:0] CFG_IN_ROWS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_IN_COLS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_CHAN_GROUPS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_POOL_SIZE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_ROW_STRIDE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_COL_STRIDE  = 3'd5;

   typedef logic [LANES-1:0][SAMPLE_BITS-1:0] lane_vec_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] lane7;
      logic signed [SAMPLE_BITS-1:0] lane6;
      logic signed [SAMPLE_BITS-1:0] lane5;
      logic signed [SAMPLE_BITS-1:0] lane4;
      logic signed [SAMPLE_BITS-1:0] lane3;
      logic signed [SAMPLE_BITS-1:0] lane2;
      logic signed [SAMPLE_BITS-1:0] lane1;
      logic signed [SAMPLE_BITS-1:0] lane0;
   } req_type;

   typedef struct packed {
      logic                          frame_last;
      logic                          plane_last;
      logic signed [SAMPLE_BITS-1:0] avg7;
      logic signed [SAMPLE_BITS-1:0] avg6;
      logic signed [SAMPLE_BITS-1:0] avg5;
      logic signed [SAMPLE_BITS-1:0] avg4;
      logic signed [SAMPLE_BITS-1:0] avg3;
      logic signed [SAMPLE_BITS-1:0] avg2;
      logic signed [SAMPLE_BITS-1:0] avg1;
      logic signed [SAMPLE_BITS-1:0] avg0;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [POS_W-1:0]     data;
   } csr_type;

   // one classified item handed from the front to the back
   typedef struct packed {
      lane_vec_type      data;
      logic [SLOT_W-1:0] wr_slot;
      logic [POS_W-1:0]  wr_col;
      logic              win;
      logic [SLOT_W-1:0] rd_slot;
      logic [POS_W-1:0]  c0;
      logic [SIZE_W-1:0] p;
      logic              plane_last;
      logic              frame_last;
   } work_type;

   // rounded q1.16 reciprocal of size squared
   function automatic logic [RECIP_W-1:0] recip_q16(input logic [SIZE_W-1:0] p);
      logic [RECIP_W-1:0] r;
      case (p)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd16384;
         4'd3:    r = 17'd7282;
         4'd4:    r = 17'd4096;
         4'd5:    r = 17'd2621;
         4'd6:    r = 17'd1820;
         4'd7:    r = 17'd1337;
         4'd8:    r = 17'd1024;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // one step of a restoring remainder
   function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] rem,
                                                  input logic b,
                                                  input logic [SIZE_W-1:0] d);
      logic [SIZE_W:0] t;
      t = {rem, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[SIZE_W-1:0];
   endfunction

endpackage

// ===== src/apool_if.sv =====
// handshake channels of the average pooling block
interface apool_req_if import apool_pkg::*;;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface apool_rsp_if import apool_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface apool_csr_if import apool_pkg::*;;
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/average_pooling_nhwc_8lane.sv =====
// top level of the eight-lane streaming average pooling block
// front takes one item at a time: accept, 7 remainder steps for the stride grid, hand-off
// back writes the row store, then for a window item reads its p*p pixels from its single read port
// neither side takes a new item before it has handed on the last one; a two-entry queue lies between
// synchronous reset clears positions and restores register defaults; row store is not cleared
module average_pooling_nhwc_8lane import apool_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int POOL_MAX = DEF_POOL_MAX
) (
   input  logic        clock,
   input  logic        reset,
   apool_req_if.sink   req_chan,
   apool_rsp_if.source rsp_chan,
   apool_csr_if.sink   csr_chan
);

   logic     fw_valid, fw_ready, bk_valid, bk_ready;
   work_type fw_data, bk_data;

   apool_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .POOL_MAX (POOL_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .work_valid (fw_valid),
      .work_ready (fw_ready),
      .work_data  (fw_data)
   );

   apool_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fw_valid),
      .in_ready  (fw_ready),
      .in_data   (fw_data),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (bk_data)
   );

   apool_back #(
      .MAX_COLS (MAX_COLS),
      .POOL_MAX (POOL_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (bk_valid),
      .work_ready (bk_ready),
      .work_data  (bk_data),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== src/apool_front.sv =====
// front: config registers, raster position tracking and window classification
module apool_front import apool_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int POOL_MAX = DEF_POOL_MAX
) (
   input  logic        clock,
   input  logic        reset,
   apool_req_if.sink   req_chan,
   apool_csr_if.sink   csr_chan,
   output logic        work_valid,
   input  logic        work_ready,
   output work_type    work_data
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CALC = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;
   localparam int NDIV = 4;

   logic [1:0]        state_ff, state_in;
   logic [POS_W-1:0]  in_rows_ff, in_cols_ff, chan_groups_ff;
   logic [SIZE_W-1:0] pool_size_ff, row_stride_ff, col_stride_ff;
   logic [POS_W-1:0]  row_pos_ff, col_pos_ff, group_pos_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [POS_W-1:0]  rows_c, cols_c, groups_c;
   logic [SIZE_W-1:0] p_c, rs_c, cs_c;
   logic              cand_c;
   logic [POS_W:0]    r1_c, c1_c;
   logic [SLOT_W+1:0] rds_c;
   logic [SLOT_W-1:0] rd_slot_c;
   lane_vec_type      lanes_c;

   lane_vec_type      data_ff;
   logic              cand_ff, glast_ff;
   logic [POS_W-1:0]  r0_ff, c0_ff, rlim_ff, clim_ff, wr_col_ff;
   logic [SLOT_W-1:0] wr_slot_ff, rd_slot_ff;
   logic [SIZE_W-1:0] p_ff;
   logic [NDIV-1:0][POS_W-1:0]  dvd_ff;
   logic [NDIV-1:0][SIZE_W-1:0] dvs_ff;
   logic [NDIV-1:0][SIZE_W-1:0] rem_ff;
   logic [2:0]        step_ff;

   logic accept;
   logic plane_last_c;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == F_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   // effective register values
   always_comb begin
      rows_c   = (in_rows_ff == '0) ? 7'd1 :
                 ((in_rows_ff > MAX_ROWS) ? POS_W'(MAX_ROWS) : in_rows_ff);
      cols_c   = (in_cols_ff == '0) ? 7'd1 :
                 ((in_cols_ff > MAX_COLS) ? POS_W'(MAX_COLS) : in_cols_ff);
      groups_c = (chan_groups_ff == '0) ? 7'd1 :
                 ((chan_groups_ff > 7'd64) ? 7'd64 : chan_groups_ff);
      p_c      = (pool_size_ff == '0) ? 4'd1 :
                 ((pool_size_ff > POOL_MAX) ? SIZE_W'(POOL_MAX) : pool_size_ff);
      rs_c     = (row_stride_ff == '0) ? 4'd1 : row_stride_ff;
      cs_c     = (col_stride_ff == '0) ? 4'd1 : col_stride_ff;
      r1_c     = {1'b0, row_pos_ff} + 8'd1;
      c1_c     = {1'b0, col_pos_ff} + 8'd1;
      cand_c   = (row_pos_ff < rows_c) && (col_pos_ff < cols_c) &&
                 (r1_c >= {4'd0, p_c}) && (c1_c >= {4'd0, p_c});
      // slot of the window's top row
      rds_c    = {2'b00, slot_ff} + (SLOT_W+2)'(POOL_MAX) - {1'b0, p_c} + 5'd1;
      if (rds_c >= (SLOT_W+2)'(POOL_MAX)) begin
         rds_c = rds_c - (SLOT_W+2)'(POOL_MAX);
      end
      rd_slot_c = rds_c[SLOT_W-1:0];
      lanes_c[0] = req_chan.payload.lane0;
      lanes_c[1] = req_chan.payload.lane1;
      lanes_c[2] = req_chan.payload.lane2;
      lanes_c[3] = req_chan.payload.lane3;
      lanes_c[4] = req_chan.payload.lane4;
      lanes_c[5] = req_chan.payload.lane5;
      lanes_c[6] = req_chan.payload.lane6;
      lanes_c[7] = req_chan.payload.lane7;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            if (step_ff == 3'd6) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (work_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         in_rows_ff     <= 7'd8;
         in_cols_ff     <= 7'd8;
         chan_groups_ff <= 7'd1;
         pool_size_ff   <= 4'd2;
         row_stride_ff  <= 4'd2;
         col_stride_ff  <= 4'd2;
         row_pos_ff     <= '0;
         col_pos_ff     <= '0;
         group_pos_ff   <= '0;
         slot_ff        <= '0;
         step_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid) begin
            case (csr_chan.payload.index)
               CFG_IN_ROWS:     in_rows_ff     <= csr_chan.payload.data;
               CFG_IN_COLS:     in_cols_ff     <= csr_chan.payload.data;
               CFG_CHAN_GROUPS: chan_groups_ff <= csr_chan.payload.data;
               CFG_POOL_SIZE:   pool_size_ff   <= csr_chan.payload.data[SIZE_W-1:0];
               CFG_ROW_STRIDE:  row_stride_ff  <= csr_chan.payload.data[SIZE_W-1:0];
               CFG_COL_STRIDE:  col_stride_ff  <= csr_chan.payload.data[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            step_ff <= '0;
            if (c1_c >= {1'b0, cols_c}) begin
               col_pos_ff <= '0;
               if (r1_c >= {1'b0, rows_c}) begin
                  row_pos_ff <= '0;
                  slot_ff    <= '0;
                  if ({1'b0, group_pos_ff} + 8'd1 >= {1'b0, groups_c}) begin
                     group_pos_ff <= '0;
                  end else begin
                     group_pos_ff <= group_pos_ff + 7'd1;
                  end
               end else begin
                  row_pos_ff <= r1_c[POS_W-1:0];
                  slot_ff    <= (slot_ff == SLOT_W'(POOL_MAX - 1)) ? '0 : slot_ff + 3'd1;
               end
            end else begin
               col_pos_ff <= c1_c[POS_W-1:0];
            end
         end else if (state_ff == F_CALC) begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   // item capture and remainder iterations for the stride grid tests
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff    <= lanes_c;
         cand_ff    <= cand_c;
         glast_ff   <= ({1'b0, group_pos_ff} + 8'd1 >= {1'b0, groups_c});
         r0_ff      <= r1_c[POS_W-1:0] - {3'd0, p_c};
         c0_ff      <= c1_c[POS_W-1:0] - {3'd0, p_c};
         rlim_ff    <= rows_c - {3'd0, p_c};
         clim_ff    <= cols_c - {3'd0, p_c};
         wr_col_ff  <= col_pos_ff;
         wr_slot_ff <= slot_ff;
         rd_slot_ff <= rd_slot_c;
         p_ff       <= p_c;
         dvd_ff[0]  <= r1_c[POS_W-1:0] - {3'd0, p_c};
         dvd_ff[1]  <= c1_c[POS_W-1:0] - {3'd0, p_c};
         dvd_ff[2]  <= rows_c - {3'd0, p_c};
         dvd_ff[3]  <= cols_c - {3'd0, p_c};
         dvs_ff[0]  <= rs_c;
         dvs_ff[1]  <= cs_c;
         dvs_ff[2]  <= rs_c;
         dvs_ff[3]  <= cs_c;
         rem_ff     <= '0;
      end else if (state_ff == F_CALC) begin
         for (int k = 0; k < NDIV; k++) begin
            rem_ff[k] <= rem_step(rem_ff[k], dvd_ff[k][POS_W-1], dvs_ff[k]);
            dvd_ff[k] <= {dvd_ff[k][POS_W-2:0], 1'b0};
         end
      end
   end

   assign plane_last_c = (r0_ff == rlim_ff - {3'd0, rem_ff[2]}) &&
                         (c0_ff == clim_ff - {3'd0, rem_ff[3]});

   always_comb begin
      work_valid           = (state_ff == F_PUSH);
      work_data.data       = data_ff;
      work_data.wr_slot    = wr_slot_ff;
      work_data.wr_col     = wr_col_ff;
      work_data.win        = cand_ff && (rem_ff[0] == '0) && (rem_ff[1] == '0);
      work_data.rd_slot    = rd_slot_ff;
      work_data.c0         = c0_ff;
      work_data.p          = p_ff;
      work_data.plane_last = plane_last_c;
      work_data.frame_last = plane_last_c && glast_ff;
   end

endmodule

// ===== src/apool_fifo.sv =====
// two-entry queue between the front and the back
module apool_fifo import apool_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_data
);

   work_type   entry_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= in_data;
      end
   end

endmodule

// ===== src/apool_back.sv =====
// back: row store, window summation, reciprocal scaling and result register
module apool_back import apool_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int POOL_MAX = DEF_POOL_MAX
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       work_valid,
   output logic       work_ready,
   input  work_type   work_data,
   apool_rsp_if.source rsp_chan
);

   localparam int SLOT_IW = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
   localparam int COL_IW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_READ = 3'd1;
   localparam logic [2:0] B_TAIL = 3'd2;
   localparam logic [2:0] B_MUL  = 3'd3;
   localparam logic [2:0] B_OUT  = 3'd4;

   lane_vec_type mem [POOL_MAX][MAX_COLS];

   logic [2:0]        state_ff, state_in;
   work_type          entry_ff;
   logic [SIZE_W-1:0] i_ff, j_ff;
   logic [SLOT_W-1:0] rslot_ff;
   logic [POS_W-1:0]  col_ff;
   lane_vec_type      rd_data_ff;
   logic              rd_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff  [LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   lane_vec_type      avg_c;
   logic              pop, last_col, last_row, load_out;

   assign work_ready = (state_ff == B_IDLE);
   assign pop        = work_valid && work_ready;
   assign last_col   = (j_ff == entry_ff.p - 4'd1);
   assign last_row   = (i_ff == entry_ff.p - 4'd1);
   assign load_out   = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop && work_data.win) begin
               state_in = B_READ;
            end
         end
         B_READ: begin
            if (last_col && last_row) begin
               state_in = B_TAIL;
            end
         end
         B_TAIL: state_in = B_MUL;
         B_MUL:  state_in = B_OUT;
         B_OUT: begin
            if (load_out) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == B_READ);
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // row store: written on every item, read one window pixel per cycle
   always_ff @(posedge clock) begin
      if (pop) begin
         mem[SLOT_IW'(work_data.wr_slot)][COL_IW'(work_data.wr_col)] <= work_data.data;
      end
      rd_data_ff <= mem[SLOT_IW'(rslot_ff)][COL_IW'(col_ff)];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff <= work_data;
         i_ff     <= '0;
         j_ff     <= '0;
         rslot_ff <= work_data.rd_slot;
         col_ff   <= work_data.c0;
      end else if (state_ff == B_READ) begin
         if (last_col) begin
            j_ff     <= '0;
            col_ff   <= entry_ff.c0;
            i_ff     <= i_ff + 4'd1;
            rslot_ff <= (rslot_ff == SLOT_W'(POOL_MAX - 1)) ? '0 : rslot_ff + 3'd1;
         end else begin
            j_ff   <= j_ff + 4'd1;
            col_ff <= col_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (pop) begin
            acc_ff[k] <= '0;
         end else if (rd_valid_ff) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'($signed(rd_data_ff[k]));
         end
         if (state_ff == B_MUL) begin
            prod_ff[k] <= PROD_W'(acc_ff[k]) *
                          PROD_W'($signed({1'b0, recip_q16(entry_ff.p)}));
         end
      end
   end

   // floor shift and saturation to the sample range
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if ((prod_ff[k] >>> 16) > PROD_W'(32767)) begin
            avg_c[k] = 16'h7fff;
         end else if ((prod_ff[k] >>> 16) < -PROD_W'(32768)) begin
            avg_c[k] = 16'h8000;
         end else begin
            avg_c[k] = prod_ff[k][16 +: SAMPLE_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff.avg0       <= avg_c[0];
         rsp_data_ff.avg1       <= avg_c[1];
         rsp_data_ff.avg2       <= avg_c[2];
         rsp_data_ff.avg3       <= avg_c[3];
         rsp_data_ff.avg4       <= avg_c[4];
         rsp_data_ff.avg5       <= avg_c[5];
         rsp_data_ff.avg6       <= avg_c[6];
         rsp_data_ff.avg7       <= avg_c[7];
         rsp_data_ff.plane_last <= entry_ff.plane_last;
         rsp_data_ff.frame_last <= entry_ff.frame_last;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule
